// ----- rtl/core/dsmsfd_pkg.sv -----
// Shared constants, types and tables for the serial frame decoder.
package dsmsfd_pkg;

  localparam int FRAME_BYTES  = 16;
  localparam int NUM_CHANNELS = 16;
  localparam int MAX_PAIRS    = 7;
  localparam int NUM_PAIRS    = (FRAME_BYTES / 2 - 1 < MAX_PAIRS) ? FRAME_BYTES / 2 - 1
                                                                  : MAX_PAIRS;
  localparam int RAM_DEPTH    = FRAME_BYTES / 2;
  localparam int IDX_W        = $clog2(FRAME_BYTES);
  localparam int PAIR_W       = $clog2(RAM_DEPTH);

  localparam logic [7:0] MODE_1024   = 8'h01;
  localparam logic [7:0] MODE_2048_A = 8'h12;
  localparam logic [7:0] MODE_2048_B = 8'ha2;
  localparam logic [7:0] MODE_2048_C = 8'hb2;

  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_GAP     = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  localparam logic [7:0] NO_CH         = 8'hff;
  localparam logic [7:0] FAIL_SAT      = 8'hff;
  localparam logic [7:0] MAX_FAILS_RST = 8'd10;

  // value = 1000 * (v + 1025) / 1366, division by reciprocal multiply
  localparam int    SCALE_MUL   = 1000;
  localparam int    SCALE_OFS   = 1025;
  localparam int    SCALE_DIV   = 1366;
  localparam int    RECIP_SHIFT = 32;
  localparam longint RECIP      = (longint'(1) << RECIP_SHIFT) / SCALE_DIV;

  typedef enum logic [1:0] {
    KIND_UPDATE,
    KIND_DONE,
    KIND_FAIL,
    KIND_STOP
  } kind_t;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_FRAME,
    PH_STOP
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_FAIL,
    ST_EMIT_STOP,
    ST_READ,
    ST_CALC1,
    ST_CALC2,
    ST_EMIT_CH,
    ST_EMIT_DONE
  } state_t;

  typedef struct packed {
    logic  store_byte;
    logic  idx_clear;
    logic  fail_inc;
    logic  fail_clear;
    logic  pair_start;
    logic  pair_next;
    logic  out_load;
    kind_t out_kind;
    logic  out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic mode_ok;
    logic lim;
    logic out_free;
    logic pair_last;
    logic ch_ok;
  } dp_status_t;

  function automatic logic [7:0] id_map(input logic [3:0] id);
    logic [7:0] ch;
    unique case (id)
      4'd0:    ch = 8'd2;
      4'd1:    ch = 8'd0;
      4'd2:    ch = 8'd1;
      4'd3:    ch = 8'd3;
      4'd4:    ch = 8'd4;
      4'd5:    ch = 8'd5;
      4'd6:    ch = 8'd6;
      4'd7:    ch = 8'd7;
      4'd8:    ch = 8'd8;
      4'd9:    ch = 8'd9;
      default: ch = NO_CH;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/dsmsfd_if.sv -----
// Event and result channel interfaces for the serial frame decoder.
interface dsmsfd_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;
  modport source(output valid, func, rx_byte, input ready);
  modport sink(input valid, func, rx_byte, output ready);
endinterface

interface dsmsfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  channel;
  logic [11:0] value;
  logic [7:0]  fail_count;
  logic        last;
  modport source(output valid, kind, channel, value, fail_count, last, input ready);
  modport sink(input valid, kind, channel, value, fail_count, last, output ready);
endinterface

// ----- rtl/core/dsmsfd_ram.sv -----
// Generic single write, single read RAM with registered read data.
module dsmsfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/dsmsfd_dp.sv -----
// Datapath: frame store, counters, value scaling pipeline and result register.
module dsmsfd_dp
  import dsmsfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic [7:0]         rx_byte,
  input  dp_cmd_t            cmd,
  output dp_status_t         st,
  dsmsfd_res_if.source       res
);

  logic [7:0]        max_fails;
  logic [7:0]        failures;
  logic [IDX_W-1:0]  idx;
  logic [7:0]        hi_byte;
  logic [7:0]        mode;
  logic [PAIR_W-1:0] pair;

  logic [15:0]       rdata;
  logic              ram_we;
  logic [PAIR_W-1:0] waddr;

  // scaling pipeline
  logic              mode10;
  logic [10:0]       v;
  logic [3:0]        id;
  logic [7:0]        ch_map;
  logic [11:0]       v_ofs;
  logic [21:0]       x;
  logic [3:0]        ch;
  logic              ch_ok;
  logic [43:0]       prod;
  logic [11:0]       q0;
  logic [21:0]       x2;
  logic [21:0]       qd;
  logic [21:0]       rem;
  logic [11:0]       val;
  logic              out_free;

  assign ram_we = cmd.store_byte & idx[0];
  assign waddr  = PAIR_W'(idx >> 1);

  dsmsfd_ram #(
    .WIDTH(16),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata({hi_byte, rx_byte}),
    .raddr(pair),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fails <= MAX_FAILS_RST;
      failures  <= '0;
      idx       <= '0;
      pair      <= '0;
    end else begin
      if (cfg_we) begin
        max_fails <= cfg_data;
      end
      if (cmd.fail_clear) begin
        failures <= '0;
      end else if (cmd.fail_inc && failures != FAIL_SAT) begin
        failures <= failures + 8'd1;
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.store_byte) begin
        idx <= st.idx_last ? '0 : idx + IDX_W'(1);
      end
      if (cmd.pair_start) begin
        pair <= PAIR_W'(1);
      end else if (cmd.pair_next) begin
        pair <= pair + PAIR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte && !idx[0]) begin
      hi_byte <= rx_byte;
    end
    if (cmd.store_byte && idx == IDX_W'(1)) begin
      mode <= rx_byte;
    end
  end

  // stage 1: unpack the pair and offset/scale by the constant
  always_comb begin
    mode10 = (mode == MODE_1024);
    if (mode10) begin
      v  = {rdata[9:8], rdata[7:0], 1'b0};
      id = rdata[13:10];
    end else begin
      v  = {rdata[10:8], rdata[7:0]};
      id = rdata[14:11];
    end
    ch_map = id_map(id);
    v_ofs  = {1'b0, v} + 12'(SCALE_OFS);
  end

  assign prod = 44'(x) * 44'(RECIP);
  assign qd   = 22'(q0) * 22'(SCALE_DIV);
  assign rem  = x2 - qd;
  // reciprocal is rounded down, so the quotient is at most one short
  assign val  = q0 + 12'(rem >= 22'(SCALE_DIV));

  always_ff @(posedge clk) begin
    x     <= 22'(v_ofs) * 22'(SCALE_MUL);
    ch    <= ch_map[3:0];
    ch_ok <= (ch_map < 8'(NUM_CHANNELS));
    q0    <= prod[RECIP_SHIFT +: 12];
    x2    <= x;
  end

  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.kind       <= cmd.out_kind;
      res.last       <= cmd.out_last;
      res.fail_count <= cmd.fail_clear ? 8'd0 : failures;
      if (cmd.out_kind == KIND_UPDATE) begin
        res.channel <= ch;
        res.value   <= val;
      end else begin
        res.channel <= '0;
        res.value   <= '0;
      end
    end
  end

  always_comb begin
    st.idx_last  = (idx == IDX_W'(FRAME_BYTES - 1));
    st.mode_ok   = (mode == MODE_1024) || (mode == MODE_2048_A) ||
                   (mode == MODE_2048_B) || (mode == MODE_2048_C);
    st.lim       = (failures >= max_fails);
    st.out_free  = out_free;
    st.pair_last = (pair == PAIR_W'(NUM_PAIRS));
    st.ch_ok     = ch_ok;
  end

endmodule

// ----- rtl/core/dsmsfd_ctrl.sv -----
// Controller: event handling, link phase and result sequencing.
module dsmsfd_ctrl
  import dsmsfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  dsmsfd_evt_if.sink    evt,
  input  dp_status_t    st,
  output dp_cmd_t       cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_WAIT;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign evt.ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.out_kind = KIND_UPDATE;
    unique case (state)
      ST_IDLE: begin
        if (evt.valid) begin
          if (phase == PH_STOP || st.lim) begin
            phase_next = PH_STOP;
            state_next = ST_EMIT_STOP;
          end else begin
            priority case (evt.func)
              FUNC_TIMEOUT: begin
                cmd.fail_inc  = 1'b1;
                cmd.idx_clear = 1'b1;
                phase_next    = PH_WAIT;
                state_next    = ST_EMIT_FAIL;
              end
              FUNC_GAP: begin
                if (phase == PH_WAIT) begin
                  phase_next    = PH_FRAME;
                  cmd.idx_clear = 1'b1;
                end
              end
              FUNC_BYTE: begin
                if (phase == PH_FRAME) begin
                  cmd.store_byte = 1'b1;
                  if (st.idx_last) begin
                    if (!st.mode_ok) begin
                      cmd.fail_inc = 1'b1;
                      phase_next   = PH_WAIT;
                      state_next   = ST_EMIT_FAIL;
                    end else begin
                      cmd.pair_start = 1'b1;
                      state_next     = ST_READ;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_EMIT_FAIL: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_FAIL;
          if (st.lim) begin
            phase_next = PH_STOP;
            state_next = ST_EMIT_STOP;
          end else begin
            cmd.out_last = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end
      ST_EMIT_STOP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_STOP;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_READ:  state_next = ST_CALC1;
      ST_CALC1: state_next = ST_CALC2;
      ST_CALC2: state_next = ST_EMIT_CH;
      ST_EMIT_CH: begin
        // unmapped ids move on without a transfer
        if (!st.ch_ok || st.out_free) begin
          cmd.out_load = st.ch_ok;
          if (st.pair_last) begin
            state_next = ST_EMIT_DONE;
          end else begin
            cmd.pair_next = 1'b1;
            state_next    = ST_READ;
          end
        end
      end
      ST_EMIT_DONE: begin
        if (st.out_free) begin
          cmd.fail_clear = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_kind   = KIND_DONE;
          cmd.out_last   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/dsm_serial_frame_decoder_unit.sv -----
// Top level of the serial frame decoder.
// A byte or gap that gives no result leaves the controller idle, ready for the next event.
// A failure or stopped event passes through the emit states; at a frame end each decoded pair goes
// through the read, two scaling and emit states in turn, then a done result; no event is taken meanwhile.
// The last result sits in the output register while the next event is taken.
// Synchronous reset: wait for gap, failure count zero, failure limit 10; frame store not cleared.
module dsm_serial_frame_decoder_unit
  import dsmsfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  dsmsfd_evt_if.sink    evt,
  dsmsfd_res_if.source  res
);

  dp_cmd_t    cmd;
  dp_status_t st;

  dsmsfd_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .evt(evt),
    .st (st),
    .cmd(cmd)
  );

  dsmsfd_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .rx_byte (evt.rx_byte),
    .cmd     (cmd),
    .st      (st),
    .res     (res)
  );

endmodule
